// ===== rtl/c2s_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table of the
// cartesian to spherical converter. No dependencies.
`timescale 1ns / 1ps

package c2s_pkg;

   // Defaults of the top level parameters.
   localparam int DEF_COORD_WIDTH   = 24;
   localparam int DEF_CORDIC_STAGES = 16;

   // Fixed result field widths.
   localparam int RADIUS_WIDTH   = 24;
   localparam int POLAR_WIDTH    = 16;
   localparam int AZIMUTH_WIDTH  = 17;
   localparam int RSP_DATA_WIDTH = 64;
   localparam int RSP_PAD_WIDTH  = RSP_DATA_WIDTH - RADIUS_WIDTH - POLAR_WIDTH - AZIMUTH_WIDTH;
   localparam int RSP_USER_WIDTH = 1;

   // Two square roots run side by side: the full radius and the xy radius.
   localparam int NUM_ROOTS = 2;
   localparam int SQ_RADIUS = 0;
   localparam int SQ_RHO    = 1;

   // Two CORDIC lanes: azimuth atan2(y, x) and polar atan2(rho, z).
   localparam int NUM_LANES = 2;
   localparam int LANE_AZ   = 0;
   localparam int LANE_POL  = 1;

   // Guard bits in front of the CORDIC datapath (multiply by 256).
   localparam int GUARD_SHIFT = 8;
   // Extra integer bits of the CORDIC datapath above the guarded input.
   localparam int CORDIC_EXTRA = 11;

   // Angle accumulator: 2^31 equals pi, 2^16 accumulator units are one angle unit.
   localparam int ACC_WIDTH      = 34;
   localparam int ANGLE_SHIFT    = 16;
   localparam int ANGLE_WIDTH    = ACC_WIDTH - ANGLE_SHIFT;
   localparam int ATAN_TABLE_LEN = 24;

   localparam logic signed [ACC_WIDTH-1:0] ACC_PI =
      {{(ACC_WIDTH-32){1'b0}}, 32'h8000_0000};
   localparam logic signed [ACC_WIDTH-1:0] ACC_HALF =
      {{(ACC_WIDTH-16){1'b0}}, 16'h8000};

   localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_PI   = ANGLE_WIDTH'(32768);
   localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_TURN = ANGLE_WIDTH'(65536);
   localparam logic signed [ANGLE_WIDTH-1:0] AZ_LOW     = -ANGLE_WIDTH'(32767);

   localparam logic [RADIUS_WIDTH-1:0] RADIUS_MAX = {RADIUS_WIDTH{1'b1}};

   typedef struct packed {
      logic                     zero_point;
      logic [AZIMUTH_WIDTH-1:0] azimuth;
      logic [POLAR_WIDTH-1:0]   polar_angle;
      logic [RADIUS_WIDTH-1:0]  radius;
   } c2s_result_type;

   // atan(2^-i) scaled so that 2^31 equals pi, rounded to nearest.
   function automatic logic signed [ACC_WIDTH-1:0] atan_entry(input int idx);
      logic signed [ACC_WIDTH-1:0] val;
      case (idx)
         0:  val = ACC_WIDTH'(536870912);
         1:  val = ACC_WIDTH'(316933406);
         2:  val = ACC_WIDTH'(167458907);
         3:  val = ACC_WIDTH'(85004756);
         4:  val = ACC_WIDTH'(42667331);
         5:  val = ACC_WIDTH'(21354465);
         6:  val = ACC_WIDTH'(10679838);
         7:  val = ACC_WIDTH'(5340245);
         8:  val = ACC_WIDTH'(2670163);
         9:  val = ACC_WIDTH'(1335087);
         10: val = ACC_WIDTH'(667544);
         11: val = ACC_WIDTH'(333772);
         12: val = ACC_WIDTH'(166886);
         13: val = ACC_WIDTH'(83443);
         14: val = ACC_WIDTH'(41722);
         15: val = ACC_WIDTH'(20861);
         16: val = ACC_WIDTH'(10430);
         17: val = ACC_WIDTH'(5215);
         18: val = ACC_WIDTH'(2608);
         19: val = ACC_WIDTH'(1304);
         20: val = ACC_WIDTH'(652);
         21: val = ACC_WIDTH'(326);
         22: val = ACC_WIDTH'(163);
         23: val = ACC_WIDTH'(81);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/c2s_front.sv =====
// Front end of the converter: input register, magnitudes, squares and sums.
// Three register stages. Depends on c2s_pkg.
`timescale 1ns / 1ps

module c2s_front import c2s_pkg::*; #(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic signed [COORD_WIDTH-1:0]   in_x,
   input  logic signed [COORD_WIDTH-1:0]   in_y,
   input  logic signed [COORD_WIDTH-1:0]   in_z,
   output logic                            out_valid,
   output logic        [2*COORD_WIDTH-1:0] out_sum_xy,
   output logic        [2*COORD_WIDTH-1:0] out_sum_xyz,
   output logic signed [COORD_WIDTH-1:0]   out_x,
   output logic signed [COORD_WIDTH-1:0]   out_y,
   output logic signed [COORD_WIDTH-1:0]   out_z
);

   localparam int W    = COORD_WIDTH;
   localparam int SQ_W = 2 * COORD_WIDTH;

   logic [2:0] valid_ff;

   logic signed [W-1:0] x1_ff, y1_ff, z1_ff;
   logic        [W-1:0] mx1_ff, my1_ff, mz1_ff;
   logic        [W-1:0] mx1_in, my1_in, mz1_in;

   logic signed [W-1:0]  x2_ff, y2_ff, z2_ff;
   logic        [SQ_W-1:0] sqx2_ff, sqy2_ff, sqz2_ff;
   logic        [SQ_W-1:0] sqx2_in, sqy2_in, sqz2_in;

   logic signed [W-1:0]  x3_ff, y3_ff, z3_ff;
   logic        [SQ_W-1:0] sxy3_ff, sxyz3_ff;
   logic        [SQ_W-1:0] sxy3_in, sxyz3_in;

   // The most negative value negates onto itself, which as unsigned is its magnitude.
   always_comb begin
      mx1_in = in_x[W-1] ? $unsigned(-in_x) : $unsigned(in_x);
      my1_in = in_y[W-1] ? $unsigned(-in_y) : $unsigned(in_y);
      mz1_in = in_z[W-1] ? $unsigned(-in_z) : $unsigned(in_z);

      sqx2_in = SQ_W'(mx1_ff) * SQ_W'(mx1_ff);
      sqy2_in = SQ_W'(my1_ff) * SQ_W'(my1_ff);
      sqz2_in = SQ_W'(mz1_ff) * SQ_W'(mz1_ff);

      sxy3_in  = sqx2_ff + sqy2_ff;
      sxyz3_in = sqx2_ff + sqy2_ff + sqz2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff    <= in_x;
         y1_ff    <= in_y;
         z1_ff    <= in_z;
         mx1_ff   <= mx1_in;
         my1_ff   <= my1_in;
         mz1_ff   <= mz1_in;
         x2_ff    <= x1_ff;
         y2_ff    <= y1_ff;
         z2_ff    <= z1_ff;
         sqx2_ff  <= sqx2_in;
         sqy2_ff  <= sqy2_in;
         sqz2_ff  <= sqz2_in;
         x3_ff    <= x2_ff;
         y3_ff    <= y2_ff;
         z3_ff    <= z2_ff;
         sxy3_ff  <= sxy3_in;
         sxyz3_ff <= sxyz3_in;
      end
   end

   assign out_valid   = valid_ff[2];
   assign out_sum_xy  = sxy3_ff;
   assign out_sum_xyz = sxyz3_ff;
   assign out_x       = x3_ff;
   assign out_y       = y3_ff;
   assign out_z       = z3_ff;

endmodule

// ===== rtl/c2s_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, two radicands side by
// side, followed by a round-to-nearest stage. Depends on c2s_pkg.
`timescale 1ns / 1ps

module c2s_sqrt import c2s_pkg::*; #(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH,
   parameter int SIDE_WIDTH  = 3 * DEF_COORD_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [2*COORD_WIDTH-1:0]     in_radicand [NUM_ROOTS],
   input  logic [SIDE_WIDTH-1:0]        in_side,
   output logic                         out_valid,
   output logic [COORD_WIDTH-1:0]       out_root [NUM_ROOTS],
   output logic [SIDE_WIDTH-1:0]        out_side
);

   localparam int W  = COORD_WIDTH;
   localparam int RW = 2 * COORD_WIDTH;
   localparam int TW = 2 * COORD_WIDTH + 1;

   // The remainder always equals radicand minus the square of the partial root.
   logic [RW-1:0] rem_src [W][NUM_ROOTS];
   logic [RW-1:0] rem_in  [W][NUM_ROOTS];
   logic [RW-1:0] rem_ff  [W][NUM_ROOTS];
   logic [W-1:0]  q_src   [W][NUM_ROOTS];
   logic [W-1:0]  q_in    [W][NUM_ROOTS];
   logic [W-1:0]  q_ff    [W][NUM_ROOTS];
   logic [SIDE_WIDTH-1:0] side_ff [W];
   logic                  valid_ff [W];
   logic [TW-1:0]         term;

   logic [W-1:0]          root_in  [NUM_ROOTS];
   logic [W-1:0]          root_ff  [NUM_ROOTS];
   logic [SIDE_WIDTH-1:0] rside_ff;
   logic                  rvalid_ff;

   always_comb begin
      for (int l = 0; l < NUM_ROOTS; l++) begin
         rem_src[0][l] = in_radicand[l];
         q_src[0][l]   = '0;
      end
      for (int j = 1; j < W; j++) begin
         for (int l = 0; l < NUM_ROOTS; l++) begin
            rem_src[j][l] = rem_ff[j-1][l];
            q_src[j][l]   = q_ff[j-1][l];
         end
      end
      term = '0;
      // Stage j decides root bit k = W-1-j: (q + 2^k)^2 - q^2 = q*2^(k+1) + 2^(2k).
      for (int j = 0; j < W; j++) begin
         for (int l = 0; l < NUM_ROOTS; l++) begin
            term = (TW'(q_src[j][l]) << (W - j)) + (TW'(1) << (2 * (W - 1 - j)));
            if (TW'(rem_src[j][l]) >= term) begin
               rem_in[j][l] = rem_src[j][l] - term[RW-1:0];
               q_in[j][l]   = q_src[j][l] | (W'(1) << (W - 1 - j));
            end else begin
               rem_in[j][l] = rem_src[j][l];
               q_in[j][l]   = q_src[j][l];
            end
         end
      end
      // Round up when the remainder exceeds the floor root.
      for (int l = 0; l < NUM_ROOTS; l++) begin
         if (rem_ff[W-1][l] > RW'(q_ff[W-1][l])) begin
            root_in[l] = q_ff[W-1][l] + 1'b1;
         end else begin
            root_in[l] = q_ff[W-1][l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < W; j++) begin
            valid_ff[j] <= 1'b0;
         end
         rvalid_ff <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int j = 1; j < W; j++) begin
            valid_ff[j] <= valid_ff[j-1];
         end
         rvalid_ff <= valid_ff[W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < W; j++) begin
            for (int l = 0; l < NUM_ROOTS; l++) begin
               rem_ff[j][l] <= rem_in[j][l];
               q_ff[j][l]   <= q_in[j][l];
            end
         end
         side_ff[0] <= in_side;
         for (int j = 1; j < W; j++) begin
            side_ff[j] <= side_ff[j-1];
         end
         for (int l = 0; l < NUM_ROOTS; l++) begin
            root_ff[l] <= root_in[l];
         end
         rside_ff <= side_ff[W-1];
      end
   end

   assign out_valid = rvalid_ff;
   assign out_root  = root_ff;
   assign out_side  = rside_ff;

endmodule

// ===== rtl/c2s_cordic.sv =====
// Unrolled vectoring CORDIC, two atan2 lanes side by side: a prerotation
// stage followed by one register stage per rotation. Depends on c2s_pkg.
`timescale 1ns / 1ps

module c2s_cordic import c2s_pkg::*; #(
   parameter int COORD_WIDTH   = DEF_COORD_WIDTH,
   parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
   parameter int SIDE_WIDTH    = DEF_COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic signed [COORD_WIDTH:0]   in_a [NUM_LANES],
   input  logic signed [COORD_WIDTH:0]   in_b [NUM_LANES],
   input  logic        [SIDE_WIDTH-1:0]  in_side,
   output logic                          out_valid,
   output logic signed [ACC_WIDTH-1:0]   out_acc [NUM_LANES],
   output logic                          out_zero [NUM_LANES],
   output logic        [SIDE_WIDTH-1:0]  out_side
);

   localparam int NS = CORDIC_STAGES;
   localparam int CW = COORD_WIDTH + CORDIC_EXTRA;

   // Index 0 holds the prerotated vector, index j+1 the vector after rotation j.
   logic signed [CW-1:0]        a_in   [0:NS][NUM_LANES];
   logic signed [CW-1:0]        a_ff   [0:NS][NUM_LANES];
   logic signed [CW-1:0]        b_in   [0:NS][NUM_LANES];
   logic signed [CW-1:0]        b_ff   [0:NS][NUM_LANES];
   logic signed [ACC_WIDTH-1:0] acc_in [0:NS][NUM_LANES];
   logic signed [ACC_WIDTH-1:0] acc_ff [0:NS][NUM_LANES];
   logic                        zero_in [0:NS][NUM_LANES];
   logic                        zero_ff [0:NS][NUM_LANES];
   logic        [SIDE_WIDTH-1:0] side_ff [0:NS];
   logic                         valid_ff [0:NS];

   logic signed [CW-1:0] a_ext, b_ext, a_sh, b_sh;

   always_comb begin
      a_ext = '0;
      b_ext = '0;
      a_sh  = '0;
      b_sh  = '0;
      // Prerotation: a vector in the left half plane is turned by pi.
      for (int l = 0; l < NUM_LANES; l++) begin
         a_ext = CW'(in_a[l]);
         b_ext = CW'(in_b[l]);
         zero_in[0][l] = (in_a[l] == '0) && (in_b[l] == '0);
         if (in_a[l][COORD_WIDTH]) begin
            a_in[0][l]   = (-a_ext) <<< GUARD_SHIFT;
            b_in[0][l]   = (-b_ext) <<< GUARD_SHIFT;
            acc_in[0][l] = in_b[l][COORD_WIDTH] ? -ACC_PI : ACC_PI;
         end else begin
            a_in[0][l]   = a_ext <<< GUARD_SHIFT;
            b_in[0][l]   = b_ext <<< GUARD_SHIFT;
            acc_in[0][l] = '0;
         end
      end
      // Rotation j drives b toward zero.
      for (int j = 0; j < NS; j++) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            a_sh = a_ff[j][l] >>> j;
            b_sh = b_ff[j][l] >>> j;
            if (b_ff[j][l][CW-1]) begin
               a_in[j+1][l]   = a_ff[j][l] - b_sh;
               b_in[j+1][l]   = b_ff[j][l] + a_sh;
               acc_in[j+1][l] = acc_ff[j][l] - atan_entry(j);
            end else begin
               a_in[j+1][l]   = a_ff[j][l] + b_sh;
               b_in[j+1][l]   = b_ff[j][l] - a_sh;
               acc_in[j+1][l] = acc_ff[j][l] + atan_entry(j);
            end
            zero_in[j+1][l] = zero_ff[j][l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= NS; j++) begin
            valid_ff[j] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int j = 1; j <= NS; j++) begin
            valid_ff[j] <= valid_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j <= NS; j++) begin
            for (int l = 0; l < NUM_LANES; l++) begin
               a_ff[j][l]    <= a_in[j][l];
               b_ff[j][l]    <= b_in[j][l];
               acc_ff[j][l]  <= acc_in[j][l];
               zero_ff[j][l] <= zero_in[j][l];
            end
         end
         side_ff[0] <= in_side;
         for (int j = 1; j <= NS; j++) begin
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   assign out_valid = valid_ff[NS];
   assign out_acc   = acc_ff[NS];
   assign out_zero  = zero_ff[NS];
   assign out_side  = side_ff[NS];

endmodule

// ===== rtl/c2s_out.sv =====
// Result formatting (angle rounding, wrap and clamp, radius saturation) and the
// output register with one skid entry that stalls the pipeline. Depends on c2s_pkg.
`timescale 1ns / 1ps

module c2s_out import c2s_pkg::*; #(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [COORD_WIDTH-1:0]      in_radius,
   input  logic signed [ACC_WIDTH-1:0] in_acc [NUM_LANES],
   input  logic                        in_zero [NUM_LANES],
   input  logic                        rsp_tready,
   output logic                        en,
   output logic                        out_valid,
   output c2s_result_type              out_result
);

   localparam int EXT_W = (COORD_WIDTH > RADIUS_WIDTH) ? COORD_WIDTH : RADIUS_WIDTH;

   logic [EXT_W-1:0]             rad_ext;
   logic signed [ACC_WIDTH-1:0]  acc_rnd [NUM_LANES];
   logic signed [ANGLE_WIDTH-1:0] ang    [NUM_LANES];
   logic signed [ANGLE_WIDTH-1:0] az_w, pol_w;
   c2s_result_type               result_in;

   c2s_result_type out_ff, skid_ff;
   logic           out_valid_ff, skid_valid_ff;
   logic           take, out_free;

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         acc_rnd[l] = in_acc[l] + ACC_HALF;
         ang[l]     = $signed(acc_rnd[l][ACC_WIDTH-1:ANGLE_SHIFT]);
      end

      // Azimuth is kept in (-pi, pi]: minus pi reads as plus pi.
      if (in_zero[LANE_AZ]) begin
         az_w = '0;
      end else if (ang[LANE_AZ] > ANGLE_PI) begin
         az_w = ang[LANE_AZ] - ANGLE_TURN;
      end else if (ang[LANE_AZ] < AZ_LOW) begin
         az_w = ang[LANE_AZ] + ANGLE_TURN;
      end else begin
         az_w = ang[LANE_AZ];
      end

      if (in_zero[LANE_POL] || ang[LANE_POL][ANGLE_WIDTH-1]) begin
         pol_w = '0;
      end else if (ang[LANE_POL] > ANGLE_PI) begin
         pol_w = ANGLE_PI;
      end else begin
         pol_w = ang[LANE_POL];
      end

      rad_ext = EXT_W'(in_radius);
      if (rad_ext > EXT_W'(RADIUS_MAX)) begin
         result_in.radius = RADIUS_MAX;
      end else begin
         result_in.radius = rad_ext[RADIUS_WIDTH-1:0];
      end
      result_in.polar_angle = pol_w[POLAR_WIDTH-1:0];
      result_in.azimuth     = az_w[AZIMUTH_WIDTH-1:0];
      // The rounded radius is zero only for the origin.
      result_in.zero_point  = (in_radius == '0);
   end

   assign en       = !skid_valid_ff;
   assign take     = in_valid && en;
   assign out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= take;
         end
      end else if (take) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (take) begin
            out_ff <= result_in;
         end
      end else if (take) begin
         skid_ff <= result_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;

endmodule

// ===== rtl/cartesian_to_spherical_top.sv =====
// Top level of the cartesian to spherical converter: front end, square roots,
// CORDIC lanes and output stage. Depends on c2s_pkg and the c2s_* modules.
`timescale 1ns / 1ps

// Usage
// The req channel takes one point per beat: x, y and z as signed integers of
// COORD_WIDTH bits on a common scale. The rsp channel returns one beat per
// point: the radius on the input scale, the polar angle from +z and the
// azimuth atan2(y, x), both in binary angle units where 32768 is pi. The
// origin returns all zeros with zero_point set in rsp_tuser.
// Throughput: one point per cycle unless stalled. The square roots resolve one
// root bit per stage and the CORDIC does one rotation per stage, all unrolled.
// Reset clears every valid bit, so the pipeline, the output register and the
// skid entry come up empty; no results appear until new beats are accepted.
// Stall: when rsp_tready is low the output register holds its beat and the
// next finished result parks in a one-entry skid register. Once that entry
// is full req_tready drops and the whole pipeline freezes in place until the
// receiver takes the waiting beat; nothing is dropped or repeated.
module cartesian_to_spherical_top import c2s_pkg::*; #(
   parameter  int COORD_WIDTH    = DEF_COORD_WIDTH,
   parameter  int CORDIC_STAGES  = DEF_CORDIC_STAGES,
   localparam int REQ_DATA_WIDTH = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // x_coord, y_coord, z_coord, each COORD_WIDTH bits, from the lowest bit up
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // radius (24), polar_angle (16), azimuth (17), zero padding, from the lowest bit up
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   // zero_point
   output logic [RSP_USER_WIDTH-1:0] rsp_tuser
);

   localparam int W = COORD_WIDTH;

   // Global advance of every pipeline stage; low only while the skid entry is full.
   logic en;

   // Front end outputs.
   logic                 fr_valid;
   logic [2*W-1:0]       fr_sum_xy, fr_sum_xyz;
   logic signed [W-1:0]  fr_x, fr_y, fr_z;

   // Square root stage.
   logic [2*W-1:0]       sq_radicand [NUM_ROOTS];
   logic [3*W-1:0]       sq_side_in, sq_side_out;
   logic                 sq_valid;
   logic [W-1:0]         sq_root [NUM_ROOTS];
   logic signed [W-1:0]  sq_x, sq_y, sq_z;

   // CORDIC lanes.
   logic signed [W:0]           cd_a [NUM_LANES];
   logic signed [W:0]           cd_b [NUM_LANES];
   logic                        cd_valid;
   logic signed [ACC_WIDTH-1:0] cd_acc [NUM_LANES];
   logic                        cd_zero [NUM_LANES];
   logic [W-1:0]                cd_radius;

   c2s_result_type result;

   assign req_tready = en;

   c2s_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_tvalid),
      .in_x        ($signed(req_tdata[W-1:0])),
      .in_y        ($signed(req_tdata[2*W-1:W])),
      .in_z        ($signed(req_tdata[3*W-1:2*W])),
      .out_valid   (fr_valid),
      .out_sum_xy  (fr_sum_xy),
      .out_sum_xyz (fr_sum_xyz),
      .out_x       (fr_x),
      .out_y       (fr_y),
      .out_z       (fr_z)
   );

   // The coordinates ride along the square root pipeline for the CORDIC lanes.
   assign sq_radicand[SQ_RADIUS] = fr_sum_xyz;
   assign sq_radicand[SQ_RHO]    = fr_sum_xy;
   assign sq_side_in             = {fr_z, fr_y, fr_x};

   c2s_sqrt #(
      .COORD_WIDTH (COORD_WIDTH),
      .SIDE_WIDTH  (3 * COORD_WIDTH)
   ) u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (fr_valid),
      .in_radicand (sq_radicand),
      .in_side     (sq_side_in),
      .out_valid   (sq_valid),
      .out_root    (sq_root),
      .out_side    (sq_side_out)
   );

   assign sq_x = $signed(sq_side_out[W-1:0]);
   assign sq_y = $signed(sq_side_out[2*W-1:W]);
   assign sq_z = $signed(sq_side_out[3*W-1:2*W]);

   // Azimuth is atan2(y, x); the polar angle is atan2(rho, z).
   assign cd_a[LANE_AZ]  = (W+1)'(sq_x);
   assign cd_b[LANE_AZ]  = (W+1)'(sq_y);
   assign cd_a[LANE_POL] = (W+1)'(sq_z);
   assign cd_b[LANE_POL] = $signed({1'b0, sq_root[SQ_RHO]});

   c2s_cordic #(
      .COORD_WIDTH   (COORD_WIDTH),
      .CORDIC_STAGES (CORDIC_STAGES),
      .SIDE_WIDTH    (COORD_WIDTH)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_a      (cd_a),
      .in_b      (cd_b),
      .in_side   (sq_root[SQ_RADIUS]),
      .out_valid (cd_valid),
      .out_acc   (cd_acc),
      .out_zero  (cd_zero),
      .out_side  (cd_radius)
   );

   c2s_out #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (cd_valid),
      .in_radius  (cd_radius),
      .in_acc     (cd_acc),
      .in_zero    (cd_zero),
      .rsp_tready (rsp_tready),
      .en         (en),
      .out_valid  (rsp_tvalid),
      .out_result (result)
   );

   assign rsp_tdata = {{RSP_PAD_WIDTH{1'b0}}, result.azimuth, result.polar_angle,
                       result.radius};
   assign rsp_tuser = result.zero_point;

   // A full skid entry is only ever behind a valid output beat.
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("skid entry full while output register is empty");

   // The origin reports zero radius and zero angles.
   a_origin_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (result.radius == '0 &&
         result.polar_angle == '0 && result.azimuth == '0))
      else $error("zero point with nonzero fields");

   // The polar angle never exceeds pi.
   a_polar_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (result.polar_angle <= POLAR_WIDTH'(32768)))
      else $error("polar angle above pi");

   // Minus pi is always reported as plus pi.
   a_azimuth_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(result.azimuth) != -(AZIMUTH_WIDTH'(32768))))
      else $error("azimuth at minus pi");

endmodule
